// ===== sv/pcfd_pkg.sv =====
package pcfd_pkg;

   // Field widths of the ports.
   localparam int BYTE_W      = 8;
   localparam int PIN_MODES_W = 28;
   localparam int LEVELS_W    = 14;
   localparam int PIN_W       = 4;
   localparam int VALUE_W     = 10;

   // Pins and their mode fields.
   localparam int PIN_COUNT_DEF = 14;
   localparam int MODE_W        = 2;
   localparam int CMD_PIN_W     = 5;

   // Pin mode codes.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DIN    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUT   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PWM    = 2'd3;

   // Frame decoder phase codes.
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_LENGTH  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_SPARE   = 2'd3;

   // Payload position saturates once the two level bytes have gone by.
   localparam int POS_W = 2;
   localparam logic [POS_W-1:0] POS_LOW  = 2'd0;
   localparam logic [POS_W-1:0] POS_HIGH = 2'd1;
   localparam logic [POS_W-1:0] POS_CMD  = 2'd2;

endpackage

// ===== sv/pin_command_frame_decoder_core.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_rx_byte
// rsp_      out        rsp_valid / rsp_stall  rsp_digital_levels, rsp_levels_updated,
//                                             rsp_pwm_valid, rsp_pwm_pin, rsp_pwm_value
// csr_      in         csr_wr_en              csr_wr_data (pin modes)
//
// Every received byte gives one result, registered and presented in the cycle after its transfer.
// One byte per cycle is taken; the framing state and the result register
// are updated in the same cycle, so there is no inner loop.
// The input stalls only while a result is held and the output is stalled.
// Reset is synchronous and active high; it clears the framing state, the
// level register, the pin modes and the result valid flag.
module pin_command_frame_decoder_core #(
   parameter int PIN_COUNT = pcfd_pkg::PIN_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pcfd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcfd_pkg::LEVELS_W-1:0]     rsp_digital_levels,
   output logic                              rsp_levels_updated,
   output logic                              rsp_pwm_valid,
   output logic [pcfd_pkg::PIN_W-1:0]        rsp_pwm_pin,
   output logic [pcfd_pkg::VALUE_W-1:0]      rsp_pwm_value,
   input  logic                              csr_wr_en,
   input  logic [pcfd_pkg::PIN_MODES_W-1:0]  csr_wr_data
);

   localparam int MODE_SLOTS = 2 ** pcfd_pkg::PIN_W;

   // Configuration and framing state.
   logic [pcfd_pkg::PIN_MODES_W-1:0] pin_modes_ff;
   logic [pcfd_pkg::PHASE_W-1:0]     phase_ff, phase_in;
   logic [pcfd_pkg::BYTE_W-1:0]      bytes_left_ff, bytes_left_in;
   logic [pcfd_pkg::POS_W-1:0]       position_ff, position_in;
   logic [5:0]                       low_pins_ff, low_pins_in;
   logic [5:0]                       high_pins_ff, high_pins_in;
   logic                             awaiting_ff, awaiting_in;
   logic [pcfd_pkg::PIN_W-1:0]       pending_pin_ff, pending_pin_in;
   logic [1:0]                       pending_low_ff, pending_low_in;
   logic [pcfd_pkg::LEVELS_W-1:0]    levels_ff, levels_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pcfd_pkg::LEVELS_W-1:0]    out_levels_ff;
   logic                             out_updated_ff, out_updated_in;
   logic                             out_pwm_valid_ff, out_pwm_valid_in;
   logic [pcfd_pkg::PIN_W-1:0]       out_pwm_pin_ff, out_pwm_pin_in;
   logic [pcfd_pkg::VALUE_W-1:0]     out_pwm_value_ff, out_pwm_value_in;

   logic                             req_take;
   logic [pcfd_pkg::MODE_W-1:0]      mode_slot [MODE_SLOTS];
   logic [pcfd_pkg::LEVELS_W-1:0]    dout_mask;
   logic [pcfd_pkg::LEVELS_W-1:0]    level_src;
   logic                             latch;
   logic [pcfd_pkg::CMD_PIN_W-1:0]   cmd_pin;
   logic                             cmd_is_pwm;
   logic [pcfd_pkg::BYTE_W-1:0]      bytes_dec;

   // A new byte is taken unless a held result cannot leave.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // Per-pin mode view; slots beyond the pin count read as unused.
   for (genvar i = 0; i < MODE_SLOTS; i++) begin : g_modes
      if (i < PIN_COUNT) begin : g_real
         assign mode_slot[i] = pin_modes_ff[pcfd_pkg::MODE_W*i +: pcfd_pkg::MODE_W];
      end else begin : g_none
         assign mode_slot[i] = pcfd_pkg::MODE_UNUSED;
      end
   end

   // Pins that take their level from the frame: digital outputs from pin 2 up.
   for (genvar i = 0; i < pcfd_pkg::LEVELS_W; i++) begin : g_mask
      if (i >= 2 && i < PIN_COUNT) begin : g_pin
         assign dout_mask[i] = (mode_slot[i] == pcfd_pkg::MODE_DOUT);
      end else begin : g_fixed
         assign dout_mask[i] = 1'b0;
      end
   end

   assign level_src  = {high_pins_in, low_pins_in, 2'b00};
   assign cmd_pin    = req_rx_byte[6:2];
   assign cmd_is_pwm = ~cmd_pin[pcfd_pkg::CMD_PIN_W-1]
                       & (mode_slot[cmd_pin[pcfd_pkg::PIN_W-1:0]] == pcfd_pkg::MODE_PWM);
   assign bytes_dec  = bytes_left_ff - 8'd1;

   // Frame decoding for one byte.
   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      position_in      = position_ff;
      low_pins_in      = low_pins_ff;
      high_pins_in     = high_pins_ff;
      awaiting_in      = awaiting_ff;
      pending_pin_in   = pending_pin_ff;
      pending_low_in   = pending_low_ff;
      latch            = 1'b0;
      out_pwm_valid_in = 1'b0;
      out_pwm_pin_in   = '0;
      out_pwm_value_in = '0;
      case (phase_ff)
         pcfd_pkg::PHASE_LENGTH: begin
            bytes_left_in = req_rx_byte;
            position_in   = pcfd_pkg::POS_LOW;
            low_pins_in   = '0;
            high_pins_in  = '0;
            awaiting_in   = 1'b0;
            if (req_rx_byte == '0) begin
               latch    = 1'b1;
               phase_in = pcfd_pkg::PHASE_IDLE;
            end else begin
               phase_in = pcfd_pkg::PHASE_PAYLOAD;
            end
         end
         pcfd_pkg::PHASE_PAYLOAD: begin
            if (awaiting_ff) begin
               out_pwm_valid_in = 1'b1;
               out_pwm_pin_in   = pending_pin_ff;
               out_pwm_value_in = {req_rx_byte, pending_low_ff};
               awaiting_in      = 1'b0;
            end else if (position_ff == pcfd_pkg::POS_LOW) begin
               low_pins_in = req_rx_byte[5:0];
            end else if (position_ff == pcfd_pkg::POS_HIGH) begin
               high_pins_in = req_rx_byte[5:0];
            end else if (cmd_is_pwm) begin
               if (req_rx_byte[7] && bytes_left_ff > 8'd1) begin
                  awaiting_in    = 1'b1;
                  pending_pin_in = cmd_pin[pcfd_pkg::PIN_W-1:0];
                  pending_low_in = req_rx_byte[1:0];
               end else begin
                  out_pwm_valid_in = 1'b1;
                  out_pwm_pin_in   = cmd_pin[pcfd_pkg::PIN_W-1:0];
                  out_pwm_value_in = {8'd0, req_rx_byte[1:0]};
               end
            end
            if (position_ff != pcfd_pkg::POS_CMD) begin
               position_in = position_ff + 2'd1;
            end
            // Payload phase always holds at least one byte to go.
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               latch       = 1'b1;
               awaiting_in = 1'b0;
               phase_in    = pcfd_pkg::PHASE_IDLE;
            end
         end
         default: begin
            phase_in = (req_rx_byte == '0) ? pcfd_pkg::PHASE_LENGTH : pcfd_pkg::PHASE_IDLE;
         end
      endcase
      out_updated_in = latch;
      levels_in      = latch ? ((levels_ff & ~dout_mask) | (level_src & dout_mask)) : levels_ff;
   end

   assign rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_modes_ff   <= '0;
         phase_ff       <= pcfd_pkg::PHASE_IDLE;
         bytes_left_ff  <= '0;
         position_ff    <= pcfd_pkg::POS_LOW;
         low_pins_ff    <= '0;
         high_pins_ff   <= '0;
         awaiting_ff    <= 1'b0;
         pending_pin_ff <= '0;
         pending_low_ff <= '0;
         levels_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pin_modes_ff <= csr_wr_data;
         end
         if (req_take) begin
            phase_ff       <= phase_in;
            bytes_left_ff  <= bytes_left_in;
            position_ff    <= position_in;
            low_pins_ff    <= low_pins_in;
            high_pins_ff   <= high_pins_in;
            awaiting_ff    <= awaiting_in;
            pending_pin_ff <= pending_pin_in;
            pending_low_ff <= pending_low_in;
            levels_ff      <= levels_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         out_levels_ff    <= levels_in;
         out_updated_ff   <= out_updated_in;
         out_pwm_valid_ff <= out_pwm_valid_in;
         out_pwm_pin_ff   <= out_pwm_pin_in;
         out_pwm_value_ff <= out_pwm_value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digital_levels = out_levels_ff;
   assign rsp_levels_updated = out_updated_ff;
   assign rsp_pwm_valid      = out_pwm_valid_ff;
   assign rsp_pwm_pin        = out_pwm_pin_ff;
   assign rsp_pwm_value      = out_pwm_value_ff;

`ifndef SYNTHESIS
   // A continuation is only awaited inside a frame payload.
   a_await_in_payload: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> (phase_ff == pcfd_pkg::PHASE_PAYLOAD))
      else $error("continuation pending outside payload");

   // The payload phase always has bytes left to receive.
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pcfd_pkg::PHASE_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload phase with no bytes left");

   // The spare phase code is never entered.
   a_no_spare_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != pcfd_pkg::PHASE_SPARE)
      else $error("spare phase code entered");

   // A byte taken while idle never latches levels.
   a_idle_no_latch: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == pcfd_pkg::PHASE_IDLE) |=> !out_updated_ff)
      else $error("levels latched on a byte between frames");

   // PWM updates name a pin below the pin count, and pins 0 and 1 never get levels.
   a_pwm_pin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_pwm_valid_ff) |-> (out_pwm_pin_ff < PIN_COUNT))
      else $error("pwm update for a pin out of range");

   a_low_pins_clear: assert property (@(posedge clock) disable iff (reset)
      levels_ff[1:0] == 2'b00)
      else $error("level set on pin 0 or 1");
`endif

endmodule

// ===== tb/pin_command_frame_decoder_core_tb.sv =====
module pin_command_frame_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIN_COUNT    = pcfd_pkg::PIN_COUNT_DEF;
   localparam int FRAME_ITEMS  = 950;
   localparam int SETTLE       = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 11;
   localparam logic [pcfd_pkg::BYTE_W-1:0] HEADER = 8'h00;

   // One decoded report as it leaves the block.
   typedef struct packed {
      logic [pcfd_pkg::LEVELS_W-1:0] levels;
      logic                          updated;
      logic                          pwm_valid;
      logic [pcfd_pkg::PIN_W-1:0]    pwm_pin;
      logic [pcfd_pkg::VALUE_W-1:0]  pwm_value;
   } pin_report_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [pcfd_pkg::BYTE_W-1:0]      req_rx_byte;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [pcfd_pkg::LEVELS_W-1:0]    rsp_digital_levels;
   logic                             rsp_levels_updated;
   logic                             rsp_pwm_valid;
   logic [pcfd_pkg::PIN_W-1:0]       rsp_pwm_pin;
   logic [pcfd_pkg::VALUE_W-1:0]     rsp_pwm_value;
   logic                             csr_wr_en;
   logic [pcfd_pkg::PIN_MODES_W-1:0] csr_wr_data;

   // Reports still owed by the block, oldest first.
   pin_report_type awaited_reports[$];
   int             mismatches = 0;
   int             cycle_count = 0;
   bit             no_idle = 1'b0;

   // Mirror of the decoder state.
   logic [pcfd_pkg::PIN_MODES_W-1:0] modes_now;
   logic [pcfd_pkg::PHASE_W-1:0]     phase_now;
   logic [pcfd_pkg::BYTE_W-1:0]      left_now;
   int                               position_now;
   logic [5:0]                       low_pins_now;
   logic [5:0]                       high_pins_now;
   logic                             awaiting_now;
   logic [pcfd_pkg::PIN_W-1:0]       pending_pin_now;
   logic [1:0]                       pending_low_now;
   logic [pcfd_pkg::LEVELS_W-1:0]    levels_now;

   pin_command_frame_decoder_core #(
      .PIN_COUNT(PIN_COUNT)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digital_levels (rsp_digital_levels),
      .rsp_levels_updated (rsp_levels_updated),
      .rsp_pwm_valid      (rsp_pwm_valid),
      .rsp_pwm_pin        (rsp_pwm_pin),
      .rsp_pwm_value      (rsp_pwm_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random unless a quiet stretch is running.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d reports outstanding", $realtime,
                  awaited_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [pcfd_pkg::MODE_W-1:0] mode_of(input int pin);
      if (pin >= PIN_COUNT) return pcfd_pkg::MODE_UNUSED;
      return modes_now[2*pin +: pcfd_pkg::MODE_W];
   endfunction

   // Copy the level bytes into the level register for digital output pins only.
   function automatic void latch_levels();
      logic bit_now;
      for (int p = 2; p < PIN_COUNT; p++) begin
         if (mode_of(p) == pcfd_pkg::MODE_DOUT) begin
            bit_now = (p < 8) ? low_pins_now[p-2] : high_pins_now[p-8];
            levels_now[p] = bit_now;
         end
      end
   endfunction

   // Advance the mirrored decoder by one byte and queue the report it gives.
   function automatic void decode_byte(input logic [pcfd_pkg::BYTE_W-1:0] b);
      pin_report_type rep;
      logic [pcfd_pkg::CMD_PIN_W-1:0] pin;
      rep = '0;
      pin = b[6:2];
      case (phase_now)
         pcfd_pkg::PHASE_LENGTH: begin
            left_now = b;
            position_now = 0;
            low_pins_now = '0;
            high_pins_now = '0;
            awaiting_now = 1'b0;
            if (b == 0) begin
               latch_levels();
               rep.updated = 1'b1;
               phase_now = pcfd_pkg::PHASE_IDLE;
            end else begin
               phase_now = pcfd_pkg::PHASE_PAYLOAD;
            end
         end
         pcfd_pkg::PHASE_PAYLOAD: begin
            if (awaiting_now) begin
               rep.pwm_valid = 1'b1;
               rep.pwm_pin = pending_pin_now;
               rep.pwm_value = {b, pending_low_now};
               awaiting_now = 1'b0;
            end else if (position_now == 0) begin
               low_pins_now = b[5:0];
            end else if (position_now == 1) begin
               high_pins_now = b[5:0];
            end else if (pin < PIN_COUNT && mode_of(pin) == pcfd_pkg::MODE_PWM) begin
               if (b[7] && left_now > 1) begin
                  awaiting_now = 1'b1;
                  pending_pin_now = pin[pcfd_pkg::PIN_W-1:0];
                  pending_low_now = b[1:0];
               end else begin
                  rep.pwm_valid = 1'b1;
                  rep.pwm_pin = pin[pcfd_pkg::PIN_W-1:0];
                  rep.pwm_value = {8'h00, b[1:0]};
               end
            end
            if (position_now < 255) position_now++;
            if (left_now > 0) left_now--;
            if (left_now == 0) begin
               latch_levels();
               rep.updated = 1'b1;
               awaiting_now = 1'b0;
               phase_now = pcfd_pkg::PHASE_IDLE;
            end
         end
         default: phase_now = (b == HEADER) ? pcfd_pkg::PHASE_LENGTH : pcfd_pkg::PHASE_IDLE;
      endcase
      rep.levels = levels_now;
      awaited_reports.push_back(rep);
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
      end
   endtask

   // Every result transfer is checked against the oldest report owed.
   always @(posedge clock) begin : check_reports
      pin_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t: result transfer with no report owed, levels %0h", $realtime,
                     rsp_digital_levels);
         end else begin
            want = awaited_reports.pop_front();
            compare_field("digital_levels", 16'(want.levels), 16'(rsp_digital_levels));
            compare_field("levels_updated", 16'(want.updated), 16'(rsp_levels_updated));
            compare_field("pwm_valid", 16'(want.pwm_valid), 16'(rsp_pwm_valid));
            compare_field("pwm_pin", 16'(want.pwm_pin), 16'(rsp_pwm_pin));
            compare_field("pwm_value", 16'(want.pwm_value), 16'(rsp_pwm_value));
         end
      end
   end

   // Present one byte, possibly after a one-cycle gap, and wait for its transfer.
   // Valid stays high afterwards so back-to-back bytes need no extra edge.
   task automatic send_byte(input logic [pcfd_pkg::BYTE_W-1:0] b);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_byte(b);
   endtask

   task automatic send_frame(input logic [pcfd_pkg::BYTE_W-1:0] body[$]);
      send_byte(HEADER);
      send_byte(8'(body.size()));
      foreach (body[i]) send_byte(body[i]);
   endtask

   // Stop sending and wait until every owed report has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_modes(input logic [pcfd_pkg::PIN_MODES_W-1:0] modes);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= modes;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      modes_now = modes;
   endtask

   function automatic logic [pcfd_pkg::PIN_MODES_W-1:0] uniform_modes(
         input logic [pcfd_pkg::MODE_W-1:0] mode);
      logic [pcfd_pkg::PIN_MODES_W-1:0] m;
      m = '0;
      for (int p = 0; p < PIN_COUNT; p++) m[2*p +: pcfd_pkg::MODE_W] = mode;
      return m;
   endfunction

   function automatic logic [pcfd_pkg::BYTE_W-1:0] command_byte(input int cont,
                                                                 input int pin,
                                                                 input int low_bits);
      return {1'(cont), 5'(pin), 2'(low_bits)};
   endfunction

   // Mostly commands aimed at real pins, otherwise any byte at all.
   function automatic logic [pcfd_pkg::BYTE_W-1:0] random_command();
      if ($urandom_range(0, 99) < 75)
         return command_byte($urandom_range(0, 1), $urandom_range(0, PIN_COUNT - 1),
                             $urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [pcfd_pkg::PIN_MODES_W-1:0] pick_modes();
      logic [pcfd_pkg::PIN_MODES_W-1:0] m;
      m = '0;
      case ($urandom_range(0, 9))
         0: m = '0;
         1: m = uniform_modes(pcfd_pkg::MODE_PWM);
         2: m = uniform_modes(pcfd_pkg::MODE_DOUT);
         3: m = uniform_modes(pcfd_pkg::MODE_DIN);
         4: m = pcfd_pkg::PIN_MODES_W'($urandom);
         default: begin
            for (int p = 0; p < PIN_COUNT; p++)
               m[2*p +: pcfd_pkg::MODE_W] = ($urandom_range(0, 1) != 0) ?
                                            pcfd_pkg::MODE_PWM : pcfd_pkg::MODE_DOUT;
         end
      endcase
      return m;
   endfunction

   // Stray bytes between frames, with every pin unused.
   task automatic test_between_frames();
      write_modes(uniform_modes(pcfd_pkg::MODE_UNUSED));
      send_byte(8'hFF);
      send_byte(8'h01);
   endtask

   // Level bytes: full frame, missing high byte, and the empty frame.
   task automatic test_level_bytes();
      logic [pcfd_pkg::BYTE_W-1:0] body[$];
      write_modes(uniform_modes(pcfd_pkg::MODE_DOUT));
      body = '{8'hFF, 8'h3F};
      send_frame(body);
      body = '{8'h15};
      send_frame(body);
      body = {};
      send_frame(body);
   endtask

   // PWM commands: full scale, zero, a non-PWM pin with the continuation flag,
   // a pin out of range and a continuation missing at the end of the frame.
   task automatic test_pwm_commands();
      logic [pcfd_pkg::BYTE_W-1:0] body[$];
      logic [pcfd_pkg::PIN_MODES_W-1:0] modes;
      modes = uniform_modes(pcfd_pkg::MODE_PWM);
      modes[2*3 +: pcfd_pkg::MODE_W] = pcfd_pkg::MODE_DIN;
      write_modes(modes);
      body = '{8'h00, 8'h00, command_byte(1, 13, 3), 8'hFF, command_byte(0, 0, 0),
               command_byte(1, 3, 1), command_byte(0, 7, 2), command_byte(1, 14, 0),
               command_byte(1, 5, 2)};
      send_frame(body);
   endtask

   // The continuation still goes to a pin whose mode changed after its command.
   task automatic test_mode_change();
      send_byte(HEADER);
      send_byte(8'd4);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(command_byte(1, 6, 1));
      write_modes(uniform_modes(pcfd_pkg::MODE_UNUSED));
      send_byte(8'h80);
   endtask

   // Random frames with random mode settings, stray bytes and a quiet stretch.
   task automatic test_random_frames();
      logic [pcfd_pkg::BYTE_W-1:0] body[$];
      int sent;
      int frame_no;
      int len;
      int roll;
      sent = 0;
      frame_no = 0;
      while (sent < FRAME_ITEMS) begin
         if (frame_no % 12 == 0) write_modes(pick_modes());
         no_idle = (frame_no >= 30 && frame_no < 60);
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
         end
         roll = $urandom_range(0, 99);
         if (roll < 2) len = $urandom_range(100, 255);
         else if (roll < 12) len = $urandom_range(0, 1);
         else len = $urandom_range(2, 10);
         body = {};
         for (int i = 0; i < len; i++)
            body.push_back((i < 2) ? 8'($urandom_range(0, 255)) : random_command());
         send_frame(body);
         sent += len + 2;
         frame_no++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      modes_now = '0;
      phase_now = pcfd_pkg::PHASE_IDLE;
      left_now = '0;
      position_now = 0;
      low_pins_now = '0;
      high_pins_now = '0;
      awaiting_now = 1'b0;
      pending_pin_now = '0;
      pending_low_now = '0;
      levels_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_between_frames();
      test_level_bytes();
      test_pwm_commands();
      test_mode_change();
      test_random_frames();
      drain();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
